@@ hdl/nidc_pkg.sv @@
// Shared types, constants and small arithmetic helpers for the identity
// number checker. No dependencies; imported by nidc_eval, core and testbench.
`default_nettype none

package nidc_pkg;

    // character positions, counted from 0
    localparam logic [4:0] POS_SHORT_LAST = 5'd14;  // last char of a 15-char number
    localparam logic [4:0] POS_CHECK      = 5'd17;  // check char of an 18-char number
    localparam logic [4:0] POS_INSERT     = 5'd6;   // where "19" goes in the upgrade
    localparam logic [4:0] POS_SHORT_END  = 5'd15;
    localparam logic [4:0] POS_DATE_FIRST = 5'd6;
    localparam logic [4:0] POS_DATE_LAST  = 5'd13;
    localparam logic [4:0] POS_MAX        = 5'd31;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_X    = 8'h58;

    localparam int DATE_DIGITS = 8;

    // floor(y / 100) = (y * 5243) >> 19, exact for y below 43699
    localparam int          YEAR_PROD_W = 27;
    localparam int          YEAR_SHIFT  = 19;
    localparam logic [26:0] YEAR_RECIP  = 27'd5243;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_DATE       = 3'd1,
        ERR_CHAR       = 3'd2,
        ERR_LENGTH     = 3'd3,
        ERR_DATE_MATCH = 3'd4,
        ERR_CHECK      = 3'd5
    } nidc_err_t;

    typedef struct packed {
        logic [7:0]  char_code;
        logic        last_char;
        logic [13:0] birth_year;
        logic [3:0]  birth_month;
        logic [4:0]  birth_day;
    } nidc_item_t;

    // everything the verdict needs, frozen at the last character
    typedef struct packed {
        logic [4:0]       pos;
        logic             bad_char;
        logic [3:0]       long_sum;
        logic [3:0]       short_sum;
        logic [7:0]       char_code;
        logic [13:0]      year;
        logic [7:0]       year_q;
        logic [3:0]       month;
        logic [4:0]       day;
        logic [7:0][3:0]  digits;
    } nidc_snap_t;

    typedef struct packed {
        logic       id_valid;
        nidc_err_t  error_kind;
        logic       short_form;
        logic [7:0] upgrade_check_char;
    } nidc_result_t;

    function automatic logic [3:0] weight(input logic [4:0] idx);
        logic [3:0] w;
        case (idx)
            5'd0:  w = 4'd7;
            5'd1:  w = 4'd9;
            5'd2:  w = 4'd10;
            5'd3:  w = 4'd5;
            5'd4:  w = 4'd8;
            5'd5:  w = 4'd4;
            5'd6:  w = 4'd2;
            5'd7:  w = 4'd1;
            5'd8:  w = 4'd6;
            5'd9:  w = 4'd3;
            5'd10: w = 4'd7;
            5'd11: w = 4'd9;
            5'd12: w = 4'd10;
            5'd13: w = 4'd5;
            5'd14: w = 4'd8;
            5'd15: w = 4'd4;
            5'd16: w = 4'd2;
            default: w = 4'd0;
        endcase
        return w;
    endfunction

    function automatic logic [7:0] check_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:  c = 8'h31;
            4'd1:  c = 8'h30;
            4'd2:  c = CHAR_X;
            4'd3:  c = 8'h39;
            4'd4:  c = 8'h38;
            4'd5:  c = 8'h37;
            4'd6:  c = 8'h36;
            4'd7:  c = 8'h35;
            4'd8:  c = 8'h34;
            4'd9:  c = 8'h33;
            4'd10: c = 8'h32;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // x mod 11 for x < 128: reciprocal estimate, then one correction
    function automatic logic [3:0] mod11(input logic [6:0] x);
        logic [13:0] prod;
        logic [3:0]  q;
        logic [6:0]  r;
        prod = 14'(x) * 14'd93;
        q    = prod[13:10];
        r    = x - 7'(q) * 7'd11;
        if (r >= 7'd11)
        begin
            r = r - 7'd11;
        end
        return r[3:0];
    endfunction

    function automatic logic [3:0] add_weighted(input logic [3:0] sum,
                                                input logic [3:0] digit,
                                                input logic [3:0] w);
        return mod11(7'(sum) + 7'(digit) * 7'(w));
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] n;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     n = 5'd30;
            4'd2:                                        n = leap ? 5'd29 : 5'd28;
            default:                                     n = 5'd0;
        endcase
        return n;
    endfunction

    function automatic logic [6:0] pair_val(input logic [3:0] hi, input logic [3:0] lo);
        return 7'(hi) * 7'd10 + 7'(lo);
    endfunction

endpackage

`default_nettype wire

@@ hdl/nidc_item_if.sv @@
// Input channel: one character of an identity number plus the claimed date.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface nidc_item_if;
    logic        valid;
    logic        ready;
    logic [7:0]  char_code;
    logic        last_char;
    logic [13:0] birth_year;
    logic [3:0]  birth_month;
    logic [4:0]  birth_day;

    modport source (output valid, char_code, last_char, birth_year, birth_month, birth_day,
                    input ready);
    modport sink   (input valid, char_code, last_char, birth_year, birth_month, birth_day,
                    output ready);
endinterface

`default_nettype wire

@@ hdl/nidc_result_if.sv @@
// Output channel: verdict for one identity number.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface nidc_result_if;
    logic       valid;
    logic       ready;
    logic       id_valid;
    logic [2:0] error_kind;
    logic       short_form;
    logic [7:0] upgrade_check_char;

    modport source (output valid, id_valid, error_kind, short_form, upgrade_check_char,
                    input ready);
    modport sink   (input valid, id_valid, error_kind, short_form, upgrade_check_char,
                    output ready);
endinterface

`default_nettype wire

@@ hdl/nidc_eval.sv @@
// Verdict logic: date check, check order and check characters for one
// finished number. Combinational; depends on nidc_pkg.
`default_nettype none

module nidc_eval (
    input  nidc_pkg::nidc_snap_t   snap,
    output nidc_pkg::nidc_result_t verdict
);
    import nidc_pkg::*;

    logic [13:0] year_hundreds;
    logic [13:0] year_rem_w;
    logic [6:0]  year_rem;
    logic        leap;
    logic [4:0]  mlen;
    logic        date_ok;
    logic        short_f;
    logic        len_ok;
    logic [6:0]  yy_pair;
    logic [6:0]  mm_pair;
    logic [6:0]  dd_pair;
    logic        match_ok;
    nidc_err_t   kind;

    always_comb
    begin
        year_hundreds = 14'(snap.year_q) * 14'd100;
        year_rem_w    = snap.year - year_hundreds;
        year_rem      = year_rem_w[6:0];
        // y%400==0 is y%100==0 with the hundreds count divisible by 4
        leap = (year_rem == 7'd0) ? (snap.year_q[1:0] == 2'd0)
                                  : (snap.year[1:0] == 2'd0);
        mlen    = month_days(snap.month, leap);
        date_ok = (snap.month >= 4'd1) && (snap.month <= 4'd12) &&
                  (snap.day >= 5'd1) && (snap.day <= mlen);

        short_f = (snap.pos == POS_SHORT_LAST);
        len_ok  = short_f || (snap.pos == POS_CHECK);

        // long form has the century ahead of the year: fields sit two digits later
        yy_pair = short_f ? pair_val(snap.digits[0], snap.digits[1])
                          : pair_val(snap.digits[2], snap.digits[3]);
        mm_pair = short_f ? pair_val(snap.digits[2], snap.digits[3])
                          : pair_val(snap.digits[4], snap.digits[5]);
        dd_pair = short_f ? pair_val(snap.digits[4], snap.digits[5])
                          : pair_val(snap.digits[6], snap.digits[7]);
        match_ok = (yy_pair == year_rem) && (mm_pair == 7'(snap.month)) &&
                   (dd_pair == 7'(snap.day));

        if (!date_ok)
        begin
            kind = ERR_DATE;
        end
        else if (snap.bad_char)
        begin
            kind = ERR_CHAR;
        end
        else if (!len_ok)
        begin
            kind = ERR_LENGTH;
        end
        else if (!match_ok)
        begin
            kind = ERR_DATE_MATCH;
        end
        else if (!short_f && (check_char(snap.long_sum) != snap.char_code))
        begin
            kind = ERR_CHECK;
        end
        else
        begin
            kind = ERR_NONE;
        end

        verdict.id_valid           = (kind == ERR_NONE);
        verdict.error_kind         = kind;
        verdict.short_form         = short_f;
        verdict.upgrade_check_char = (short_f && !snap.bad_char) ? check_char(snap.short_sum)
                                                                 : 8'h00;
    end

endmodule

`default_nettype wire

@@ hdl/national_id_check_and_upgrade_core.sv @@
// Identity number checker with 15-to-18 digit upgrade. Characters arrive one
// item per cycle on the item channel; the item that carries last_char = 1 also
// carries the claimed birth date and yields one verdict on the result channel
// once it has passed the input register, the snapshot stage and the result
// register; other items yield nothing. A new item is taken every cycle while
// the result side keeps up: those stages each hold one item, so a stalled
// result only blocks the input once they are full. Rate is set by the
// per-character mod-11 weighted-sum update.
// Depends on nidc_pkg, nidc_item_if, nidc_result_if and nidc_eval.
`default_nettype none

module national_id_check_and_upgrade_core (
    input  wire logic     clk,
    input  wire logic     rst_n,
    nidc_item_if.sink     item,
    nidc_result_if.source result
);
    import nidc_pkg::*;

    // stage 1: input register
    logic         in_valid_reg;
    nidc_item_t   in_reg;

    // running state of the number being received
    logic [4:0]   pos_reg;
    logic [3:0]   long_sum_reg;
    logic [3:0]   short_sum_reg;
    logic         bad_reg;
    logic [3:0]   date_digits_reg [DATE_DIGITS];

    // stage 2: snapshot of a finished number
    logic         s2_valid_reg;
    nidc_snap_t   s2_reg;
    nidc_snap_t   s2_next;

    // stage 3: result register
    logic         res_valid_reg;
    nidc_result_t res_reg;
    nidc_result_t verdict;

    logic         res_ready;
    logic         s2_ready;
    logic         s1_fire;

    logic         is_digit;
    logic [7:0]   char_off;
    logic [3:0]   digit;
    logic         x_ok;
    logic         bad_next;
    logic [3:0]   long_sum_next;
    logic [3:0]   short_sum_next;
    logic [4:0]   pos_next;
    logic         date_wr;
    logic [4:0]   date_off;
    logic [2:0]   date_idx;
    logic [YEAR_PROD_W-1:0] year_prod;

    assign res_ready = !res_valid_reg || result.ready;
    assign s2_ready  = !s2_valid_reg || res_ready;
    // only the last character moves on to the snapshot stage
    assign s1_fire   = in_valid_reg && (!in_reg.last_char || s2_ready);
    assign item.ready = !in_valid_reg || s1_fire;

    always_comb
    begin
        char_off = in_reg.char_code - CHAR_ZERO;
        digit    = char_off[3:0];
        is_digit = (in_reg.char_code >= CHAR_ZERO) && (in_reg.char_code <= CHAR_NINE);
        x_ok     = in_reg.last_char && (pos_reg == POS_CHECK) && (in_reg.char_code == CHAR_X);
        bad_next = bad_reg || (!is_digit && !x_ok);

        long_sum_next = long_sum_reg;
        if (is_digit && (pos_reg < POS_CHECK))
        begin
            long_sum_next = add_weighted(long_sum_reg, digit, weight(pos_reg));
        end

        // inserted "19" contributes 1*2 + 9*1 = 11, which is 0 mod 11
        short_sum_next = short_sum_reg;
        if (is_digit && (pos_reg < POS_INSERT))
        begin
            short_sum_next = add_weighted(short_sum_reg, digit, weight(pos_reg));
        end
        else if (is_digit && (pos_reg < POS_SHORT_END))
        begin
            short_sum_next = add_weighted(short_sum_reg, digit, weight(pos_reg + 5'd2));
        end

        pos_next = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 5'd1;

        date_wr  = is_digit && (pos_reg >= POS_DATE_FIRST) && (pos_reg <= POS_DATE_LAST);
        date_off = pos_reg - POS_DATE_FIRST;
        date_idx = date_off[2:0];

        year_prod = YEAR_PROD_W'(in_reg.birth_year) * YEAR_RECIP;

        s2_next.pos       = pos_reg;
        s2_next.bad_char  = bad_next;
        s2_next.long_sum  = long_sum_next;
        s2_next.short_sum = short_sum_next;
        s2_next.char_code = in_reg.char_code;
        s2_next.year      = in_reg.birth_year;
        s2_next.year_q    = year_prod[YEAR_SHIFT +: 8];
        s2_next.month     = in_reg.birth_month;
        s2_next.day       = in_reg.birth_day;
        // a date digit is never written by a last character that reaches the
        // date comparison, so the stored digits are already complete here
        for (int i = 0; i < DATE_DIGITS; i++)
        begin
            s2_next.digits[i] = date_digits_reg[i];
        end
    end

    nidc_eval u_eval (
        .snap    (s2_reg),
        .verdict (verdict)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            pos_reg       <= 5'd0;
            long_sum_reg  <= 4'd0;
            short_sum_reg <= 4'd0;
            bad_reg       <= 1'b0;
            s2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (item.ready)
            begin
                in_valid_reg <= item.valid;
            end

            if (s1_fire)
            begin
                if (in_reg.last_char)
                begin
                    pos_reg       <= 5'd0;
                    long_sum_reg  <= 4'd0;
                    short_sum_reg <= 4'd0;
                    bad_reg       <= 1'b0;
                end
                else
                begin
                    pos_reg       <= pos_next;
                    long_sum_reg  <= long_sum_next;
                    short_sum_reg <= short_sum_next;
                    bad_reg       <= bad_next;
                end
            end

            if (s2_ready)
            begin
                s2_valid_reg <= s1_fire && in_reg.last_char;
            end

            if (res_ready)
            begin
                res_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            in_reg.char_code   <= item.char_code;
            in_reg.last_char   <= item.last_char;
            in_reg.birth_year  <= item.birth_year;
            in_reg.birth_month <= item.birth_month;
            in_reg.birth_day   <= item.birth_day;
        end
        if (s1_fire && date_wr)
        begin
            date_digits_reg[date_idx] <= digit;
        end
        if (s2_ready && s1_fire && in_reg.last_char)
        begin
            s2_reg <= s2_next;
        end
        if (res_ready && s2_valid_reg)
        begin
            res_reg <= verdict;
        end
    end

    assign result.valid              = res_valid_reg;
    assign result.id_valid           = res_reg.id_valid;
    assign result.error_kind         = res_reg.error_kind;
    assign result.short_form         = res_reg.short_form;
    assign result.upgrade_check_char = res_reg.upgrade_check_char;

`ifndef NO_ASSERTIONS
    ap_sums_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (long_sum_reg < 4'd11) && (short_sum_reg < 4'd11))
        else $error("mod-11 sum out of range");

    ap_pos_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg == POS_MAX && s1_fire && !in_reg.last_char) |=> (pos_reg == POS_MAX))
        else $error("character position wrapped");

    ap_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && in_reg.last_char) |=>
        (pos_reg == 5'd0 && long_sum_reg == 4'd0 && short_sum_reg == 4'd0 && !bad_reg))
        else $error("number state not cleared after last character");

    ap_last_reaches_snapshot: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && in_reg.last_char) |=> s2_valid_reg)
        else $error("last character lost before snapshot stage");

    ap_valid_matches_kind: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_reg.id_valid == (res_reg.error_kind == ERR_NONE)))
        else $error("id_valid disagrees with error kind");

    ap_upgrade_only_short: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_reg.short_form) |-> (res_reg.upgrade_check_char == 8'h00))
        else $error("upgrade character given for a long number");
`endif

endmodule

`default_nettype wire

@@ test/national_id_check_and_upgrade_core_test.sv @@
`timescale 1ns / 100ps
// Testbench for national_id_check_and_upgrade_core: streams identity numbers
// one character per item and checks every verdict against a local predictor.
// Depends on nidc_pkg, nidc_item_if, nidc_result_if and the core itself.

module national_id_check_and_upgrade_core_test;

    import nidc_pkg::*;

    logic clk = 1'b0;
    logic rst_n;

    nidc_item_if   item_ch ();
    nidc_result_if verdict_ch ();

    national_id_check_and_upgrade_core i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (verdict_ch)
    );

    always #2 clk = ~clk;

    // predictor state
    logic [4:0] char_pos;
    logic [3:0] long_sum;
    logic [3:0] short_sum;
    logic       saw_bad_char;
    logic [3:0] date_mem [8];

    nidc_result_t verdict_due [$];
    logic [7:0]   id_chars [$];
    int           fail_count = 0;
    int           items_sent = 0;
    int           gap_pct    = 13;

    function automatic int pos_weight(input int p);
        case (p)
            0, 10:  return 7;
            1, 11:  return 9;
            2, 12:  return 10;
            3, 13:  return 5;
            4, 14:  return 8;
            5, 15:  return 4;
            6, 16:  return 2;
            7:      return 1;
            8:      return 6;
            9:      return 3;
            default: return 0;
        endcase
    endfunction

    function automatic logic [7:0] check_for_sum(input int s);
        case (s)
            0:  return "1";
            1:  return "0";
            2:  return CHAR_X;
            3:  return "9";
            4:  return "8";
            5:  return "7";
            6:  return "6";
            7:  return "5";
            8:  return "4";
            9:  return "3";
            10: return "2";
            default: return 8'h00;
        endcase
    endfunction

    function automatic int month_length(input int m, input int y);
        bit leap;
        leap = (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    function automatic int digit_pair(input int k);
        return int'(date_mem[3'(k)]) * 10 + int'(date_mem[3'(k + 1)]);
    endfunction

    // Advances the predictor by one character; returns 1 when a verdict is due.
    function automatic bit score_character(input nidc_item_t it,
                                           output nidc_result_t verdict);
        int unsigned pos;
        int unsigned dig;
        int unsigned len;
        int unsigned base;
        int          y;
        int          m;
        int          d;
        bit          is_digit;
        nidc_err_t   kind;
        pos      = 32'(char_pos);
        is_digit = (it.char_code >= CHAR_ZERO) && (it.char_code <= CHAR_NINE);
        dig      = 32'(it.char_code - CHAR_ZERO);
        verdict  = '0;
        // 'X' passes only as the check char of an 18-char number
        if (!is_digit && !(it.last_char && pos == 17 && it.char_code == CHAR_X))
            saw_bad_char = 1'b1;
        if (is_digit)
        begin
            if (pos < 17)
                long_sum = 4'((int'(long_sum) + dig * pos_weight(pos)) % 11);
            if (pos < 6)
                short_sum = 4'((int'(short_sum) + dig * pos_weight(pos)) % 11);
            else if (pos < 15)
                short_sum = 4'((int'(short_sum) + dig * pos_weight(pos + 2)) % 11);
            if (pos >= 6 && pos <= 13)
                date_mem[3'(pos - 6)] = 4'(dig);
        end
        // inserted "19": 1 at weight 2, 9 at weight 1
        if (pos == 6)
            short_sum = 4'((int'(short_sum) + 11) % 11);
        if (!it.last_char)
        begin
            if (char_pos < 5'd31)
                char_pos = char_pos + 5'd1;
            return 1'b0;
        end
        y    = int'(it.birth_year);
        m    = int'(it.birth_month);
        d    = int'(it.birth_day);
        len  = pos + 1;
        base = (len == 15) ? 0 : 2;
        if (m < 1 || m > 12 || d < 1 || d > month_length(m, y))
            kind = ERR_DATE;
        else if (saw_bad_char)
            kind = ERR_CHAR;
        else if (len != 15 && len != 18)
            kind = ERR_LENGTH;
        else if (digit_pair(base) != y % 100 || digit_pair(base + 2) != m ||
                 digit_pair(base + 4) != d)
            kind = ERR_DATE_MATCH;
        else if (len == 18 && check_for_sum(int'(long_sum)) != it.char_code)
            kind = ERR_CHECK;
        else
            kind = ERR_NONE;
        verdict.id_valid           = (kind == ERR_NONE);
        verdict.error_kind         = kind;
        verdict.short_form         = (len == 15);
        verdict.upgrade_check_char = (len == 15 && !saw_bad_char) ?
                                     check_for_sum(int'(short_sum)) : 8'h00;
        char_pos     = '0;
        long_sum     = '0;
        short_sum    = '0;
        saw_bad_char = 1'b0;
        return 1'b1;
    endfunction

    task automatic send_char(input logic [7:0] c, input bit last,
                             input int y, input int m, input int d);
        nidc_item_t   it;
        nidc_result_t verdict;
        it.char_code   = c;
        it.last_char   = last;
        it.birth_year  = 14'(y);
        it.birth_month = 4'(m);
        it.birth_day   = 5'(d);
        while ($urandom_range(99) < gap_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.char_code   <= it.char_code;
        item_ch.last_char   <= it.last_char;
        item_ch.birth_year  <= it.birth_year;
        item_ch.birth_month <= it.birth_month;
        item_ch.birth_day   <= it.birth_day;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        if (score_character(it, verdict))
            verdict_due.push_back(verdict);
        items_sent++;
    endtask

    // date fields only matter on the last char; others carry noise
    task automatic send_id(input int y, input int m, input int d);
        for (int i = 0; i < id_chars.size(); i++)
        begin
            if (i == id_chars.size() - 1)
                send_char(id_chars[i], 1'b1, y, m, d);
            else
                send_char(id_chars[i], 1'b0, $urandom_range(9999), $urandom_range(15),
                          $urandom_range(31));
        end
    endtask

    function automatic logic [7:0] rand_digit();
        return CHAR_ZERO + 8'($urandom_range(9));
    endfunction

    function automatic void put_pair(input int v);
        id_chars.push_back(CHAR_ZERO + 8'((v % 100) / 10));
        id_chars.push_back(CHAR_ZERO + 8'(v % 10));
    endfunction

    // well-formed number whose date digits match the given date
    function automatic void build_id(input bit long_form, input int y, input int m,
                                     input int d);
        int s;
        id_chars.delete();
        for (int i = 0; i < 6; i++)
            id_chars.push_back(rand_digit());
        if (long_form)
            put_pair(y / 100);
        put_pair(y);
        put_pair(m);
        put_pair(d);
        for (int i = 0; i < 3; i++)
            id_chars.push_back(rand_digit());
        if (long_form)
        begin
            s = 0;
            for (int i = 0; i < 17; i++)
                s = (s + int'(id_chars[i] - CHAR_ZERO) * pos_weight(i)) % 11;
            id_chars.push_back(check_for_sum(s));
        end
    endfunction

    function automatic void build_digits(input int n);
        id_chars.delete();
        for (int i = 0; i < n; i++)
            id_chars.push_back(rand_digit());
    endfunction

    task automatic pick_date(output int y, output int m, output int d);
        y = $urandom_range(9999);
        m = $urandom_range(1, 12);
        d = $urandom_range(1, month_length(m, y));
    endtask

    task automatic test_valid_ids();
        build_id(1'b1, 1987, 6, 15);
        send_id(1987, 6, 15);
        build_id(1'b0, 1965, 12, 31);
        send_id(1965, 12, 31);
        // keep drawing until the check char comes out as 'X'
        do
            build_id(1'b1, 2004, 1, 1);
        while (id_chars[17] != CHAR_X);
        send_id(2004, 1, 1);
    endtask

    task automatic test_date_checks();
        build_id(1'b1, 0, 2, 29);       // year 0 is a leap year
        send_id(0, 2, 29);
        build_id(1'b1, 1900, 2, 29);
        send_id(1900, 2, 29);
        build_id(1'b0, 2000, 2, 29);
        send_id(2000, 2, 29);
        build_id(1'b1, 9999, 0, 10);
        send_id(9999, 0, 10);
        build_id(1'b0, 1999, 15, 10);
        send_id(1999, 15, 10);
        build_id(1'b1, 1980, 5, 0);
        send_id(1980, 5, 0);
        build_id(1'b1, 1980, 4, 31);
        send_id(1980, 4, 31);
    endtask

    task automatic test_char_checks();
        build_id(1'b1, 1970, 3, 3);
        id_chars[3] = "A";
        send_id(1970, 3, 3);
        build_id(1'b1, 1970, 3, 3);
        id_chars[10] = CHAR_X;
        send_id(1970, 3, 3);
        build_id(1'b1, 1970, 3, 3);
        id_chars[17] = "x";
        send_id(1970, 3, 3);
        build_id(1'b0, 1970, 3, 3);
        id_chars[14] = CHAR_X;
        send_id(1970, 3, 3);
        build_id(1'b0, 1970, 3, 3);
        id_chars[0] = 8'hFF;
        id_chars[5] = 8'h00;
        id_chars[2] = 8'h2F;
        id_chars[7] = 8'h3A;
        send_id(1970, 3, 3);
    endtask

    task automatic test_length_checks();
        build_digits(1);
        send_id(2010, 10, 10);
        build_digits(16);
        send_id(2010, 10, 10);
        build_digits(17);
        send_id(2010, 10, 10);
        build_digits(19);
        send_id(2010, 10, 10);
        // position counter saturates well before the end of this one
        build_digits(40);
        send_id(2010, 10, 10);
    endtask

    task automatic test_match_and_check_digit();
        build_id(1'b0, 1955, 7, 21);
        id_chars[11] = CHAR_ZERO + 8'(2);
        send_id(1955, 7, 21);
        build_id(1'b1, 1955, 7, 21);
        id_chars[9] = CHAR_ZERO + 8'(4);
        send_id(1955, 7, 21);
        build_id(1'b1, 1955, 7, 21);
        id_chars[17] = (id_chars[17] == CHAR_ZERO) ? "1" : "0";
        send_id(1955, 7, 21);
    endtask

    task automatic test_random_ids();
        int first;
        int sel;
        int y;
        int m;
        int d;
        first = items_sent;
        while (items_sent - first < 550)
        begin
            // a stretch in the middle runs with no gaps on either side
            gap_pct = (items_sent - first >= 150 && items_sent - first < 350) ? 0 : 13;
            sel = $urandom_range(99);
            pick_date(y, m, d);
            build_id(1'($urandom_range(1)), y, m, d);
            if (sel >= 60 && sel < 70)
                id_chars[$urandom_range(id_chars.size() - 1)] = rand_digit();
            else if (sel >= 70 && sel < 78)
            begin
                m = $urandom_range(15);
                d = $urandom_range(31);
                build_id(1'($urandom_range(1)), y, m, d);
            end
            else if (sel >= 78 && sel < 86)
                build_digits($urandom_range(1, 34));
            else if (sel >= 86 && sel < 93)
                id_chars[$urandom_range(id_chars.size() - 1)] = 8'($urandom_range(255));
            else if (sel >= 93)
                id_chars[id_chars.size() - 1] = check_for_sum($urandom_range(10));
            send_id(y, m, d);
        end
        gap_pct = 13;
    endtask

    always @(posedge clk)
        verdict_ch.ready <= ($urandom_range(99) >= gap_pct);

    always @(posedge clk)
    begin
        nidc_result_t want;
        if (rst_n && verdict_ch.valid && verdict_ch.ready)
        begin
            if (verdict_due.size() == 0)
            begin
                $error("verdict with none pending");
                fail_count++;
            end
            else
            begin
                want = verdict_due.pop_front();
                if (verdict_ch.id_valid !== want.id_valid)
                begin
                    $error("id_valid: expected %0d, got %0d", want.id_valid,
                           verdict_ch.id_valid);
                    fail_count++;
                end
                if (verdict_ch.error_kind !== want.error_kind)
                begin
                    $error("error_kind: expected %0d, got %0d", want.error_kind,
                           verdict_ch.error_kind);
                    fail_count++;
                end
                if (verdict_ch.short_form !== want.short_form)
                begin
                    $error("short_form: expected %0d, got %0d", want.short_form,
                           verdict_ch.short_form);
                    fail_count++;
                end
                if (verdict_ch.upgrade_check_char !== want.upgrade_check_char)
                begin
                    $error("upgrade_check_char: expected %02h, got %02h",
                           want.upgrade_check_char, verdict_ch.upgrade_check_char);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        char_pos     = '0;
        long_sum     = '0;
        short_sum    = '0;
        saw_bad_char = 1'b0;
        for (int i = 0; i < 8; i++)
            date_mem[i] = '0;
        rst_n                  <= 1'b0;
        item_ch.valid          <= 1'b0;
        item_ch.char_code      <= '0;
        item_ch.last_char      <= 1'b0;
        item_ch.birth_year     <= '0;
        item_ch.birth_month    <= '0;
        item_ch.birth_day      <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_valid_ids();
        test_date_checks();
        test_char_checks();
        test_length_checks();
        test_match_and_check_digit();
        test_random_ids();

        item_ch.valid <= 1'b0;
        while (verdict_due.size() != 0)
            @(posedge clk);
        // catch any stray verdict after the last one
        repeat (12) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/nidc_pkg.sv
hdl/nidc_item_if.sv
hdl/nidc_result_if.sv
hdl/nidc_eval.sv
hdl/national_id_check_and_upgrade_core.sv
test/national_id_check_and_upgrade_core_test.sv
